FILE: hdl/dqmb_pkg.sv
`timescale 1ns / 1ps

package dqmb_pkg;

  localparam int BUF_BYTES_DEF = 512;
  localparam int LABEL_MAX_DEF = 63;

  localparam int CFG_W = 10;
  localparam logic [CFG_W-1:0] CFG_CAP_RESET = 10'd512;

  localparam int OFF_W = 9;
  localparam int STEP_W = 5;
  // Longest run: twelve header bytes plus six closing bytes.
  localparam logic [STEP_W-1:0] MAX_STEP = 5'd17;
  localparam int HDR_BYTES = 12;

  localparam logic [7:0] DOT_CHAR = 8'd46;
  localparam logic [7:0] END_CHAR = 8'd0;
  localparam logic [3:0] OPCODE_STD = 4'd0;
  localparam logic [15:0] QUERY_FLAGS = {1'b0, OPCODE_STD, 2'b00, 1'b1, 8'd0};
  localparam logic [15:0] QCLASS_INET = 16'd1;
  localparam logic [15:0] QD_COUNT = 16'd1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_BUILD,
    MODE_DISCARD
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_LABEL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [7:0]       wbyte;
    logic             run_last;
    logic             frame_done;
    status_t          status;
  } res_t;

  // Fixed 12-byte query header: id, flags, QDCOUNT 1, zero AN/NS/AR counts.
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
    logic [7:0] b;
    case (idx)
      4'd0:    b = id[15:8];
      4'd1:    b = id[7:0];
      4'd2:    b = QUERY_FLAGS[15:8];
      4'd3:    b = QUERY_FLAGS[7:0];
      4'd4:    b = QD_COUNT[15:8];
      4'd5:    b = QD_COUNT[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/dqmb_gen.sv
`timescale 1ns / 1ps

module dqmb_gen #(
  parameter int POS_W     = 10,
  parameter int LC_W      = 6,
  parameter int LABEL_MAX = 63
) (
  input  dqmb_pkg::mode_t                  mode,
  input  logic [dqmb_pkg::STEP_W-1:0]      step,
  input  logic [7:0]                       name_char,
  input  logic [15:0]                      query_id,
  input  logic [15:0]                      query_type,
  input  logic [POS_W-1:0]                 wp,
  input  logic [POS_W-1:0]                 lp,
  input  logic [LC_W-1:0]                  lc,
  input  logic [POS_W-1:0]                 cap,
  output logic                             emit,
  output logic                             last,
  output logic                             err,
  output dqmb_pkg::res_t                   res,
  output dqmb_pkg::mode_t                  nxt_mode,
  output logic [POS_W-1:0]                 nxt_wp,
  output logic [POS_W-1:0]                 nxt_lp,
  output logic [LC_W-1:0]                  nxt_lc
);
  import dqmb_pkg::*;

  logic              idle;
  logic [POS_W-1:0]  wp_e;
  logic [POS_W-1:0]  lp_e;
  logic [LC_W-1:0]   lc_e;
  logic [STEP_W-1:0] b;
  logic              close_fit;
  logic              wp_fit;
  status_t           err_st;

  always_comb begin
    // On the first item the header has just been laid out, so the body
    // starts from the fixed positions after it.
    idle      = (mode == MODE_IDLE);
    wp_e      = idle ? POS_W'(HDR_BYTES + 1) : wp;
    lp_e      = idle ? POS_W'(HDR_BYTES) : lp;
    lc_e      = idle ? '0 : lc;
    b         = idle ? step - STEP_W'(HDR_BYTES) : step;
    close_fit = ({1'b0, wp_e} + (POS_W+1)'(5)) <= {1'b0, cap};
    wp_fit    = wp_e < cap;

    emit   = 1'b1;
    last   = 1'b0;
    err    = 1'b0;
    err_st = ST_OK;
    res    = '{offset: '0, wbyte: '0, run_last: 1'b0, frame_done: 1'b0, status: ST_OK};

    if (mode == MODE_DISCARD) begin
      emit = 1'b0;
      last = 1'b1;
    end else if (idle && step <= STEP_W'(HDR_BYTES) && POS_W'(step) >= cap) begin
      err    = 1'b1;
      err_st = ST_OVERFLOW;
    end else if (idle && step < STEP_W'(HDR_BYTES)) begin
      res.offset = OFF_W'(step);
      res.wbyte  = hdr_byte(step[3:0], query_id);
    end else if (name_char == END_CHAR) begin
      if (!close_fit) begin
        err    = 1'b1;
        err_st = ST_OVERFLOW;
      end else begin
        unique case (b)
          5'd0: begin
            res.offset = OFF_W'(lp_e);
            res.wbyte  = 8'(lc_e);
          end
          5'd1: begin
            res.offset = OFF_W'(wp_e);
            res.wbyte  = 8'd0;
          end
          5'd2: begin
            res.offset = OFF_W'(wp_e + POS_W'(1));
            res.wbyte  = query_type[15:8];
          end
          5'd3: begin
            res.offset = OFF_W'(wp_e + POS_W'(2));
            res.wbyte  = query_type[7:0];
          end
          5'd4: begin
            res.offset = OFF_W'(wp_e + POS_W'(3));
            res.wbyte  = QCLASS_INET[15:8];
          end
          default: begin
            res.offset     = OFF_W'(wp_e + POS_W'(4));
            res.wbyte      = QCLASS_INET[7:0];
            res.frame_done = 1'b1;
            last           = 1'b1;
          end
        endcase
      end
    end else if (name_char == DOT_CHAR) begin
      // The dot always patches the closing label; reserving its own length
      // byte may then overflow, which costs one more result.
      if (b == '0) begin
        res.offset = OFF_W'(lp_e);
        res.wbyte  = 8'(lc_e);
        last       = wp_fit;
      end else begin
        err    = 1'b1;
        err_st = ST_OVERFLOW;
      end
    end else begin
      if (lc_e >= LC_W'(LABEL_MAX)) begin
        err    = 1'b1;
        err_st = ST_LABEL;
      end else if (!wp_fit) begin
        err    = 1'b1;
        err_st = ST_OVERFLOW;
      end else begin
        res.offset = OFF_W'(wp_e);
        res.wbyte  = name_char;
        last       = 1'b1;
      end
    end

    if (err) begin
      res  = '{offset: '0, wbyte: '0, run_last: 1'b1, frame_done: 1'b1, status: err_st};
      last = 1'b1;
    end
    res.run_last = last;
  end

  // State left behind once the item's last result is out.
  always_comb begin
    nxt_mode = mode;
    nxt_wp   = wp;
    nxt_lp   = lp;
    nxt_lc   = lc;
    if (mode == MODE_DISCARD) begin
      if (name_char == END_CHAR) begin
        nxt_mode = MODE_IDLE;
      end
    end else if (err || name_char == END_CHAR) begin
      nxt_mode = (err && name_char != END_CHAR) ? MODE_DISCARD : MODE_IDLE;
      nxt_wp   = '0;
      nxt_lp   = POS_W'(HDR_BYTES);
      nxt_lc   = '0;
    end else if (name_char == DOT_CHAR) begin
      nxt_mode = MODE_BUILD;
      nxt_lp   = wp_e;
      nxt_wp   = wp_e + POS_W'(1);
      nxt_lc   = '0;
    end else begin
      nxt_mode = MODE_BUILD;
      nxt_lp   = lp_e;
      nxt_wp   = wp_e + POS_W'(1);
      nxt_lc   = lc_e + LC_W'(1);
    end
  end

endmodule

FILE: hdl/dqmb_ctl.sv
`timescale 1ns / 1ps

module dqmb_ctl #(
  parameter int BUF_BYTES = 512,
  parameter int LABEL_MAX = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dqmb_pkg::CFG_W-1:0]   cfg_buffer_capacity,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_name_char,
  input  logic [15:0]                  in_query_id,
  input  logic [15:0]                  in_query_type,
  input  logic                         res_take,
  output logic                         res_valid,
  output dqmb_pkg::res_t               res
);
  import dqmb_pkg::*;

  localparam int CFG_MAX = (1 << CFG_W) - 1;
  localparam int CAP_MAX = (BUF_BYTES < CFG_MAX) ? BUF_BYTES : CFG_MAX;
  localparam int POS_W   = $clog2(CAP_MAX + 6);
  localparam int LC_W    = $clog2(LABEL_MAX + 1);

  logic [CFG_W-1:0]  cap_cfg_r;
  logic              item_v_r, item_v_nxt;
  logic [7:0]        c_r;
  logic [15:0]       id_r;
  logic [15:0]       qt_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  mode_t             mode_r;
  logic [POS_W-1:0]  wp_r;
  logic [POS_W-1:0]  lp_r;
  logic [LC_W-1:0]   lc_r;

  logic [POS_W-1:0]  cap_eff;
  logic              g_emit, g_last, g_err;
  mode_t             g_mode;
  logic [POS_W-1:0]  g_wp, g_lp;
  logic [LC_W-1:0]   g_lc;
  logic              adv, fin, acc;

  assign cap_eff = (32'(cap_cfg_r) < 32'(CAP_MAX)) ? POS_W'(cap_cfg_r) : POS_W'(CAP_MAX);

  dqmb_gen #(
    .POS_W     (POS_W),
    .LC_W      (LC_W),
    .LABEL_MAX (LABEL_MAX)
  ) u_gen (
    .mode       (mode_r),
    .step       (step_r),
    .name_char  (c_r),
    .query_id   (id_r),
    .query_type (qt_r),
    .wp         (wp_r),
    .lp         (lp_r),
    .lc         (lc_r),
    .cap        (cap_eff),
    .emit       (g_emit),
    .last       (g_last),
    .err        (g_err),
    .res        (res),
    .nxt_mode   (g_mode),
    .nxt_wp     (g_wp),
    .nxt_lp     (g_lp),
    .nxt_lc     (g_lc)
  );

  // A held item moves on one result per cycle while results are taken; an
  // item with no result finishes without waiting on the output side.
  always_comb begin
    res_valid  = item_v_r && g_emit;
    adv        = item_v_r && (!g_emit || res_take);
    fin        = adv && g_last;
    in_ready   = !item_v_r || fin;
    acc        = in_valid && in_ready;
    item_v_nxt = acc ? 1'b1 : (fin ? 1'b0 : item_v_r);
    step_nxt   = fin ? '0 : (adv ? step_r + STEP_W'(1) : step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r <= CFG_CAP_RESET;
      item_v_r  <= 1'b0;
      step_r    <= '0;
      mode_r    <= MODE_IDLE;
      wp_r      <= '0;
      lp_r      <= POS_W'(HDR_BYTES);
      lc_r      <= '0;
    end else begin
      if (cfg_we) begin
        cap_cfg_r <= cfg_buffer_capacity;
      end
      item_v_r <= item_v_nxt;
      step_r   <= step_nxt;
      if (fin) begin
        mode_r <= g_mode;
        wp_r   <= g_wp;
        lp_r   <= g_lp;
        lc_r   <= g_lc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      c_r  <= in_name_char;
      id_r <= in_query_id;
      qt_r <= in_query_type;
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    item_v_r |-> step_r <= MAX_STEP)
    else $error("result run longer than a header plus closing bytes");

  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && mode_r == MODE_DISCARD) |-> !res_valid)
    else $error("discarded character produced a result");

  a_err_to_discard: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && g_err && c_r != END_CHAR) |=> mode_r == MODE_DISCARD)
    else $error("error inside a name did not start discarding");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_done) |-> res.run_last)
    else $error("frame end is not the last result of its item");

  a_len_before_write: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_BUILD |-> wp_r > lp_r)
    else $error("write position not past the open length byte");
`endif

endmodule

FILE: hdl/dqmb_oreg.sv
`timescale 1ns / 1ps

module dqmb_oreg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_valid,
  input  dqmb_pkg::res_t                    res,
  output logic                              res_take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dqmb_pkg::OFF_W-1:0]        out_write_offset,
  output logic [7:0]                        out_write_byte,
  output logic                              out_run_last,
  output logic                              out_frame_done,
  output logic [1:0]                        out_status
);
  import dqmb_pkg::*;

  logic out_v_r;
  res_t res_r;

  // The register takes a new result whenever it is empty or being drained.
  assign res_take = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_take) begin
      out_v_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_write_offset = res_r.offset;
  assign out_write_byte   = res_r.wbyte;
  assign out_run_last     = res_r.run_last;
  assign out_frame_done   = res_r.frame_done;
  assign out_status       = res_r.status;

endmodule

FILE: hdl/dns_query_message_builder.sv
`timescale 1ns / 1ps

// DNS query builder. Takes a domain name one character per transfer on the
// in_ channel (dot separates labels, zero ends the name) and produces byte
// writes (offset, byte) into a packet buffer on the out_ channel.
// The first character of a query also yields the 12-byte header; the ending
// zero patches the last length byte and writes root, query type and class.
// Errors (buffer overflow, label too long) give one result with frame_done
// set; the rest of the name is then dropped up to its zero character.
// The run generator gives an item's results one after another and holds the
// input until the last of them is taken (one result for most characters, up
// to 18 for an empty name); items with no result do not wait on out_ready.
// An item waits in the input registers and its results pass the output
// register; one-result items flow at one per cycle while out_ready is high.
// When out_ready is low, the output register holds its result and the
// input stalls once the run generator has its next result ready.
// cfg_buffer_capacity is written by cfg_we; write it only while idle.
// Synchronous reset clears all valid flags, sets the capacity to 512
// and returns the builder to the start of a new query.
module dns_query_message_builder #(
  parameter int BUF_BYTES = dqmb_pkg::BUF_BYTES_DEF,
  parameter int LABEL_MAX = dqmb_pkg::LABEL_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dqmb_pkg::CFG_W-1:0]    cfg_buffer_capacity,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_name_char,
  input  logic [15:0]                   in_query_id,
  input  logic [15:0]                   in_query_type,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dqmb_pkg::OFF_W-1:0]    out_write_offset,
  output logic [7:0]                    out_write_byte,
  output logic                          out_run_last,
  output logic                          out_frame_done,
  output logic [1:0]                    out_status
);
  import dqmb_pkg::*;

  logic res_valid;
  logic res_take;
  res_t res;

  dqmb_ctl #(
    .BUF_BYTES (BUF_BYTES),
    .LABEL_MAX (LABEL_MAX)
  ) u_ctl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_buffer_capacity (cfg_buffer_capacity),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_name_char        (in_name_char),
    .in_query_id         (in_query_id),
    .in_query_type       (in_query_type),
    .res_take            (res_take),
    .res_valid           (res_valid),
    .res                 (res)
  );

  dqmb_oreg u_oreg (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res              (res),
    .res_take         (res_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_offset (out_write_offset),
    .out_write_byte   (out_write_byte),
    .out_run_last     (out_run_last),
    .out_frame_done   (out_frame_done),
    .out_status       (out_status)
  );

endmodule
